FILE: design/bfra_pkg.sv
// Shared constants, codes and types of the bitmap free-run allocator.
`default_nettype none
package bfra_pkg;

  localparam int unsigned MAP_BYTES = 128;
  localparam int unsigned ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BIT_SEL_W = 3;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned LIM_W     = 8;
  // Bit indices reach 1024 bits, so no more than 128 bytes are ever in use.
  localparam int unsigned INDEX_REACH_BYTES = 128;
  localparam int unsigned LIMIT_MAX =
    (MAP_BYTES < INDEX_REACH_BYTES) ? MAP_BYTES : INDEX_REACH_BYTES;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(128);

  typedef enum logic [1:0] {
    ACT_TEST  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SCAN  = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ACCESS = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  typedef struct packed {
    logic             bit_state;
    logic             found;
    logic [IDX_W-1:0] start_index;
    logic             index_error;
  } res_t;

endpackage
`default_nettype wire

FILE: design/bfra_if.sv
// Request and response channel interfaces of the bitmap free-run allocator.
`default_nettype none
interface bfra_req_if import bfra_pkg::*; ();
  logic             valid;
  logic             ready;
  action_e          action;
  logic [IDX_W-1:0] bit_index;
  logic             bit_value;
  logic [LEN_W-1:0] run_length;

  modport source (output valid, output action, output bit_index, output bit_value,
                  output run_length, input ready);
  modport sink   (input valid, input action, input bit_index, input bit_value,
                  input run_length, output ready);
endinterface

interface bfra_rsp_if import bfra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             bit_state;
  logic             found;
  logic [IDX_W-1:0] start_index;
  logic             index_error;

  modport source (output valid, output bit_state, output found, output start_index,
                  output index_error, input ready);
  modport sink   (input valid, input bit_state, input found, input start_index,
                  input index_error, output ready);
endinterface
`default_nettype wire

FILE: design/bfra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: design/bitmap_free_run_allocator.sv
// Top level of the bitmap free-run allocator: control, scan logic and bitmap RAM.
//
//  channel  | dir | handshake         | word
//  ---------+-----+-------------------+-------------------------------------------
//  req_i    | in  | valid/ready       | action, bit_index, bit_value, run_length
//  rsp_o    | out | valid/ready       | bit_state, found, start_index, index_error
//  cfg      | in  | cfg_we_i          | cfg_wdata_i = active_bytes
//
// One request at a time. A test or write goes from acceptance to the output
// register through RAM read, modify or pick, and result; an out-of-range index,
// an empty scan or an unused action goes straight to the result. A scan reads
// one bitmap byte a cycle from the single RAM read port, up to the active bytes.
// Reset clears the bitmap at once through per-byte valid bits; no clearing pass.
// A waiting result sits in the output register while the next request is taken.
`default_nettype none
module bitmap_free_run_allocator import bfra_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  bfra_req_if.sink         req_i,
  bfra_rsp_if.source       rsp_o
);

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   cfg_q;
  action_e            act_q;
  logic [IDX_W-1:0]   idx_q;
  logic               val_q;
  logic [LEN_W-1:0]   want_q;
  logic [LIM_W-1:0]   byte_q, byte_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   first_q, first_d;
  res_t               res_q, res_d;
  res_t               out_q;
  logic               out_valid_q;
  logic [MAP_BYTES-1:0] vld_q;
  logic               vld_rd_q;

  logic [LIM_W-1:0]   limit_bytes;
  logic               req_fire;
  logic               out_free;
  logic               idx_ok;
  logic               ram_re, ram_we;
  logic [ADDR_W-1:0]  ram_raddr, ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata, rd_byte;
  logic [BYTE_W-1:0]  bit_mask;

  // scan of one byte
  logic [LEN_W-1:0]   scan_cnt;
  logic [IDX_W-1:0]   scan_first;
  logic               hit;
  logic [IDX_W-1:0]   hit_start;

  assign limit_bytes = (cfg_q > LIM_W'(LIMIT_MAX)) ? LIM_W'(LIMIT_MAX) : cfg_q;
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign idx_ok      = LIM_W'(req_i.bit_index[IDX_W-1:BIT_SEL_W]) < limit_bytes;
  // Bytes never written since reset read as free.
  assign rd_byte     = vld_rd_q ? ram_rdata : '0;
  assign ram_waddr   = ADDR_W'(idx_q[IDX_W-1:BIT_SEL_W]);
  assign bit_mask    = BYTE_W'(1) << idx_q[BIT_SEL_W-1:0];

  bfra_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAP_BYTES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Walk the eight bits of the current byte; restart the run on each used bit.
  always_comb begin
    scan_cnt   = cnt_q;
    scan_first = first_q;
    hit        = 1'b0;
    hit_start  = first_q;
    for (int b = 0; b < BYTE_W; b++) begin
      if (!hit) begin
        if (rd_byte[b]) begin
          scan_cnt = '0;
        end else begin
          if (scan_cnt == '0) begin
            scan_first = IDX_W'({byte_q, BIT_SEL_W'(b)});
          end
          scan_cnt = LEN_W'(scan_cnt + 1'b1);
          if (scan_cnt == want_q) begin
            hit       = 1'b1;
            hit_start = scan_first;
          end
        end
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    byte_d    = byte_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(req_i.bit_index[IDX_W-1:BIT_SEL_W]);
    ram_we    = 1'b0;
    ram_wdata = val_q ? (rd_byte | bit_mask) : (rd_byte & ~bit_mask);
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          res_d = '0;
          case (req_i.action)
            ACT_TEST, ACT_WRITE: begin
              if (idx_ok) begin
                ram_re  = 1'b1;
                state_d = ST_ACCESS;
              end else begin
                res_d.index_error = 1'b1;
                state_d           = ST_RESP;
              end
            end
            ACT_SCAN: begin
              if (req_i.run_length != '0 && limit_bytes != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                byte_d    = '0;
                cnt_d     = '0;
                first_d   = '0;
                state_d   = ST_SCAN;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_ACCESS: begin
        if (act_q == ACT_WRITE) begin
          ram_we = 1'b1;
        end else begin
          res_d.bit_state = rd_byte[idx_q[BIT_SEL_W-1:0]];
        end
        state_d = ST_RESP;
      end
      ST_SCAN: begin
        if (hit) begin
          res_d.found       = 1'b1;
          res_d.start_index = hit_start;
          state_d           = ST_RESP;
        end else if (byte_q == LIM_W'(limit_bytes - 1'b1)) begin
          state_d = ST_RESP;
        end else begin
          // advance to the next byte, carrying the open run
          byte_d    = LIM_W'(byte_q + 1'b1);
          cnt_d     = scan_cnt;
          first_d   = scan_first;
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(byte_q + 1'b1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        vld_rd_q <= vld_q[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      act_q  <= req_i.action;
      idx_q  <= req_i.bit_index;
      val_q  <= req_i.bit_value;
      want_q <= req_i.run_length;
    end
    byte_q  <= byte_d;
    cnt_q   <= cnt_d;
    first_q <= first_d;
    res_q   <= res_d;
    if (state_q == ST_RESP && out_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.bit_state   = out_q.bit_state;
  assign rsp_o.found       = out_q.found;
  assign rsp_o.start_index = out_q.start_index;
  assign rsp_o.index_error = out_q.index_error;

  a_write_only_in_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_ACCESS && act_q == ACT_WRITE))
    else $error("bitmap written outside a write access");

  a_scan_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (byte_q < limit_bytes))
    else $error("scan ran past the active bytes");

  a_resp_holds_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_valid_q && !rsp_o.ready) |=> (state_q == ST_RESP))
    else $error("result dropped while the output register was full");

  a_found_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.found) |-> (!out_q.index_error && !out_q.bit_state))
    else $error("scan result carries test or error flags");

endmodule
`default_nettype wire

FILE: bench/tb_bitmap_free_run_allocator.sv
// Testbench for the bitmap free-run allocator: test, write and scan words against a bitmap model.
module tb_bitmap_free_run_allocator;
  import bfra_pkg::*;

  localparam logic [1:0]  ACT_UNUSED       = 2'd3;
  localparam int unsigned INDEX_REACH_BITS = 1 << IDX_W;
  localparam int unsigned SETTLE_CYCLES    = 140;   // longer than the slowest scan
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned ALLOC_MAX        = 12;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  bfra_req_if req_bus ();
  bfra_rsp_if rsp_bus ();

  bitmap_free_run_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // Model of the bitmap and its active length
  logic [BYTE_W-1:0] alloc_map [MAP_BYTES];
  logic [CFG_W-1:0]  model_active_bytes;
  res_t              pending_answers [$];
  res_t              last_answer;

  int src_idle_pct    = 0;
  int snk_stall_pct   = 0;
  int rx_hold         = 0;
  int n_words_sent    = 0;
  int n_words_checked = 0;
  int n_runs_found    = 0;
  int n_index_errors  = 0;
  int n_settings      = 0;
  int n_errors        = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned usable_bits();
    int unsigned nbytes;
    nbytes = model_active_bytes;
    if (nbytes > MAP_BYTES) nbytes = MAP_BYTES;
    return (nbytes * BYTE_W > INDEX_REACH_BITS) ? INDEX_REACH_BITS : nbytes * BYTE_W;
  endfunction

  function automatic logic search_free_run(input int unsigned want,
                                           output int unsigned run_start);
    int unsigned limit;
    int unsigned pos;
    int unsigned count;
    limit     = usable_bits();
    pos       = 0;
    count     = 0;
    run_start = 0;
    if (want == 0) return 1'b0;
    while (pos < limit) begin
      if (pos % BYTE_W == 0 && count == 0 && alloc_map[pos / BYTE_W] == '1) begin
        pos += BYTE_W;   // skip a fully used byte
      end else begin
        if (alloc_map[pos / BYTE_W][pos % BYTE_W]) begin
          count = 0;
        end else begin
          if (count == 0) run_start = pos;
          count++;
          if (count == want) return 1'b1;
        end
        pos++;
      end
    end
    run_start = 0;
    return 1'b0;
  endfunction

  function automatic res_t predict_answer(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                                          input logic val, input logic [LEN_W-1:0] len);
    res_t        r;
    int unsigned run_start;
    r = '0;
    case (act)
      ACT_TEST, ACT_WRITE: begin
        if (idx >= usable_bits()) begin
          r.index_error = 1'b1;
        end else if (act == ACT_TEST) begin
          r.bit_state = alloc_map[idx[IDX_W-1:BIT_SEL_W]][idx[BIT_SEL_W-1:0]];
        end else begin
          alloc_map[idx[IDX_W-1:BIT_SEL_W]][idx[BIT_SEL_W-1:0]] = val;
        end
      end
      ACT_SCAN: begin
        if (search_free_run(len, run_start)) begin
          r.found       = 1'b1;
          r.start_index = IDX_W'(run_start);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned bits;
    bits = usable_bits();
    if (bits == 0 || $urandom_range(99) < 10) return IDX_W'($urandom);
    return IDX_W'($urandom_range(bits - 1));
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return LEN_W'($urandom_range(16, 1));
    if (r < 80) return LEN_W'($urandom_range(usable_bits() + 8, 1));
    if (r < 95) return LEN_W'($urandom);
    return '0;
  endfunction

  task automatic send_word(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                           input logic val, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.action     <= action_e'(act);
    req_bus.bit_index  <= idx;
    req_bus.bit_value  <= val;
    req_bus.run_length <= len;
    do @(posedge clk_i); while (!req_bus.ready);
    last_answer = predict_answer(act, idx, val, len);
    pending_answers.push_back(last_answer);
    n_words_sent++;
  endtask

  task automatic drain_answers();
    req_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_active_bytes(input logic [CFG_W-1:0] value);
    drain_answers();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    model_active_bytes = value;
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Scan for a run, then claim every bit of it
  task automatic allocate_run(input int unsigned want);
    int unsigned k;
    res_t        hit;
    send_word(ACT_SCAN, IDX_W'($urandom), 1'($urandom), LEN_W'(want));
    hit = last_answer;
    if (hit.found) begin
      for (k = 0; k < want; k++)
        send_word(ACT_WRITE, hit.start_index + IDX_W'(k), 1'b1, LEN_W'($urandom));
    end
  endtask

  task automatic release_run();
    logic [IDX_W-1:0] base;
    int unsigned      span;
    int unsigned      k;
    base = pick_index();
    span = $urandom_range(8, 1);
    for (k = 0; k < span; k++)
      send_word(ACT_WRITE, base + IDX_W'(k), 1'b0, LEN_W'($urandom));
  endtask

  task automatic test_directed_edges();
    int unsigned k;
    send_word(ACT_TEST, '0, 1'b0, '0);
    send_word(ACT_TEST, '1, 1'b1, '1);
    send_word(ACT_SCAN, '0, 1'b0, '0);
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(1));
    send_word(ACT_SCAN, '1, 1'b1, LEN_W'(1024));
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(1025));
    send_word(ACT_SCAN, '1, 1'b1, '1);
    send_word(ACT_WRITE, '0, 1'b1, '0);
    send_word(ACT_WRITE, '1, 1'b1, '0);
    send_word(ACT_TEST, '0, 1'b0, '0);
    send_word(ACT_TEST, '1, 1'b0, '0);
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(1022));
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(1023));
    // fill byte 0 so that a scan starts on a full byte
    for (k = 1; k < BYTE_W; k++) send_word(ACT_WRITE, IDX_W'(k), 1'b1, '0);
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(8));
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(1));
    send_word(ACT_UNUSED, '1, 1'b1, '1);
    send_word(ACT_WRITE, '0, 1'b0, '0);
    send_word(ACT_TEST, '0, 1'b0, '0);
  endtask

  task automatic test_active_clamp();
    write_active_bytes(CFG_W'(1));
    send_word(ACT_TEST, IDX_W'(7), 1'b0, '0);
    send_word(ACT_TEST, IDX_W'(8), 1'b0, '0);
    send_word(ACT_WRITE, IDX_W'(8), 1'b1, '0);
    send_word(ACT_WRITE, '1, 1'b1, '0);
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(1));
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(2));
    write_active_bytes('0);
    send_word(ACT_TEST, '0, 1'b0, '0);
    send_word(ACT_WRITE, '0, 1'b1, '0);
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(1));
    write_active_bytes('1);
    send_word(ACT_TEST, '1, 1'b0, '0);
    send_word(ACT_TEST, IDX_W'(8), 1'b0, '0);
    send_word(ACT_SCAN, '0, 1'b0, LEN_W'(1));
    write_active_bytes(CFG_RESET);
  endtask

  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned target;
    int unsigned r;
    target = n_words_sent + n_words;
    while (n_words_sent < target) begin
      r = $urandom_range(99);
      if (r < 25) begin
        allocate_run($urandom_range(ALLOC_MAX, 1));
      end else if (r < 35) begin
        release_run();
      end else if (r < 50) begin
        send_word(ACT_WRITE, pick_index(), 1'($urandom), LEN_W'($urandom));
      end else if (r < 65) begin
        send_word(ACT_TEST, pick_index(), 1'($urandom), LEN_W'($urandom));
      end else if (r < 94) begin
        send_word(ACT_SCAN, IDX_W'($urandom), 1'($urandom), pick_len());
      end else begin
        send_word(ACT_UNUSED, IDX_W'($urandom), 1'($urandom), LEN_W'($urandom));
        target++;   // ignored words do not count
      end
    end
  endtask

  task automatic test_output_backpressure();
    int unsigned k;
    drain_answers();
    rx_hold = HOLD_CYCLES;
    for (k = 0; k < 8; k++)
      send_word((k % 2 == 1) ? ACT_SCAN : ACT_TEST, pick_index(), 1'b0, pick_len());
    // pause until every answer is back, then resume
    drain_answers();
    for (k = 0; k < 8; k++)
      send_word(ACT_SCAN, IDX_W'($urandom), 1'($urandom), pick_len());
  endtask

  // Response side: random ready, long holds on request, compare each word
  initial begin
    res_t want;
    res_t got;
    logic bad;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.bit_state   = rsp_bus.bit_state;
        got.found       = rsp_bus.found;
        got.start_index = rsp_bus.start_index;
        got.index_error = rsp_bus.index_error;
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected response word, got %p", $time, got);
          n_errors++;
        end else begin
          want = pending_answers.pop_front();
          bad  = 1'b0;
          if (got.bit_state !== want.bit_state) begin
            $display("%0t: bit_state expected %0b got %0b", $time, want.bit_state, got.bit_state);
            bad = 1'b1;
          end
          if (got.found !== want.found) begin
            $display("%0t: found expected %0b got %0b", $time, want.found, got.found);
            bad = 1'b1;
          end
          if (got.start_index !== want.start_index) begin
            $display("%0t: start_index expected %0d got %0d", $time, want.start_index,
                     got.start_index);
            bad = 1'b1;
          end
          if (got.index_error !== want.index_error) begin
            $display("%0t: index_error expected %0b got %0b", $time, want.index_error,
                     got.index_error);
            bad = 1'b1;
          end
          if (bad) n_errors++;
          n_words_checked++;
          n_runs_found   += want.found;
          n_index_errors += want.index_error;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_bus.valid      = 1'b0;
    req_bus.action     = ACT_TEST;
    req_bus.bit_index  = '0;
    req_bus.bit_value  = 1'b0;
    req_bus.run_length = '0;
    foreach (alloc_map[i]) alloc_map[i] = '0;
    model_active_bytes = CFG_RESET;
    src_idle_pct       = 10;
    snk_stall_pct      = 66;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_active_clamp();
    test_random_traffic(250);

    drain_answers();
    src_idle_pct  = 66;
    snk_stall_pct = 10;
    write_active_bytes(CFG_W'($urandom_range(16, 1)));
    test_random_traffic(100);
    write_active_bytes(CFG_W'($urandom_range(127, 17)));
    test_random_traffic(100);

    drain_answers();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_active_bytes('1);
    test_random_traffic(250);
    test_output_backpressure();

    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("checked %0d response words: %0d free runs found, %0d index errors",
             n_words_checked, n_runs_found, n_index_errors);
    $display("covered %0d active length settings, idle and stall mixes, long output hold",
             n_settings);
    if (n_errors == 0) begin
      $display("tb_bitmap_free_run_allocator: clean");
    end else begin
      $display("tb_bitmap_free_run_allocator: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d words outstanding", pending_answers.size());
    $display("tb_bitmap_free_run_allocator: errors");
    $finish;
  end

endmodule

FILE: sim.f
design/bfra_pkg.sv
design/bfra_if.sv
design/bfra_ram.sv
design/bitmap_free_run_allocator.sv
bench/tb_bitmap_free_run_allocator.sv
